@@ src/spcg_pkg.sv @@
// Shared types and constants for the sonar ping capture gate.
// No dependencies; every other file in src imports this package.
package spcg_pkg;

  localparam int CHANNELS    = 4;
  localparam int LANES       = 4;
  localparam int CHUNK_DEPTH = 1024;
  localparam int FILL_W      = $clog2(CHUNK_DEPTH + 1);

  localparam int MAG_W      = 16;
  localparam int RAW_W      = 16;
  localparam int TIME_W     = 32;
  localparam int THRESH_W   = 16;
  localparam int LIMIT_W    = 20;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 20;
  localparam int CNT_W      = $clog2(LANES + 1);

  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 112;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DETECT_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLEEP_SAMPLES    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_PING_WAIT  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_GAP_LIMIT   = 8'd3;

  typedef enum logic [1:0] {
    LANE_SLEEP   = 2'd0,
    LANE_LISTEN  = 2'd1,
    LANE_CAPTURE = 2'd2
  } lane_mode_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] sleep_samples;
    logic [LIMIT_W-1:0] first_ping_wait;
    logic [LIMIT_W-1:0] edge_gap_limit;
  } cfg_limits_t;

  // One classified time step waiting for the back end.
  typedef struct packed {
    logic [LANES-1:0]            over;
    logic [LANES-1:0][RAW_W-1:0] raw;
  } q_item_t;

endpackage

@@ src/sonar_ping_capture_gate_unit.sv @@
// Top level of the sonar ping capture gate.
// Depends on spcg_pkg, spcg_front, spcg_queue and spcg_back.
//
// Usage:
//   in_*  : one beat per multichannel time step; tdata carries the four tone
//           magnitudes and the four raw converter samples.
//   out_* : one result beat per input beat, in order: awake flag, start/take/
//           stop masks, the step index and the raw samples passed through.
//   cfg_* : register writes (threshold, sleep interval, first-ping wait, edge
//           gap limit). cfg_ready is always high; write only while idle.
// Path: an accepted input beat is classified combinationally and written into
//   the queue; the sequencer pops it and registers the result on out_*.
// Throughput: one beat per cycle while out_tready allows; the lane sequencer
//   updates all channels and the sample counters together for each beat.
// Reset (rst_n low, synchronous): block sleeping, counters and chunk fills
//   cleared, registers zero, queue and output register empty.
// Stall: when out_tready is low the result register holds; the two-entry
//   queue absorbs further beats and in_tready drops once it is full.
module sonar_ping_capture_gate_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata, lowest bit up: mag_ch0, mag_ch1, mag_ch2, mag_ch3,
  //   raw_ch0, raw_ch1, raw_ch2, raw_ch3 (16 bits each)
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [spcg_pkg::IN_DATA_W-1:0]   in_tdata,
  // out_tdata, lowest bit up: awake(1), start_mask(4), take_mask(4),
  //   stop_mask(4), step_count(32), pass_ch0..pass_ch3 (16 each), 3 zero bits
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [spcg_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [spcg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spcg_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import spcg_pkg::*;

  q_item_t     push_item;
  q_item_t     head_item;
  cfg_limits_t limits;
  logic        push;
  logic        head_valid;
  logic        pop;

  assign push = in_tvalid && in_tready;

  spcg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .push_item (push_item),
    .limits    (limits)
  );

  // Decouples intake from the sequencer so a stalled receiver does not
  // immediately back up the input.
  spcg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .push_ready (in_tready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  spcg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .limits     (limits),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ src/spcg_front.sv @@
// Front end: configuration registers and threshold classification of each input beat.
// Depends on spcg_pkg.
module spcg_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [spcg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spcg_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [spcg_pkg::IN_DATA_W-1:0]   in_tdata,
  output spcg_pkg::q_item_t                push_item,
  output spcg_pkg::cfg_limits_t            limits
);
  import spcg_pkg::*;

  logic [THRESH_W-1:0] thresh_r;
  logic [LIMIT_W-1:0]  sleep_r;
  logic [LIMIT_W-1:0]  first_wait_r;
  logic [LIMIT_W-1:0]  edge_gap_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r     <= '0;
      sleep_r      <= '0;
      first_wait_r <= '0;
      edge_gap_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DETECT_THRESHOLD: thresh_r     <= cfg_data[THRESH_W-1:0];
        REG_SLEEP_SAMPLES:    sleep_r      <= cfg_data[LIMIT_W-1:0];
        REG_FIRST_PING_WAIT:  first_wait_r <= cfg_data[LIMIT_W-1:0];
        REG_EDGE_GAP_LIMIT:   edge_gap_r   <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign limits.sleep_samples   = sleep_r;
  assign limits.first_ping_wait = first_wait_r;
  assign limits.edge_gap_limit  = edge_gap_r;

  // Magnitudes sit in the low half of tdata, raw samples in the upper half.
  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      push_item.raw[c] = in_tdata[LANES*MAG_W + c*RAW_W +: RAW_W];
      if (c < CHANNELS) begin
        push_item.over[c] = in_tdata[c*MAG_W +: MAG_W] > thresh_r;
      end else begin
        push_item.over[c] = 1'b0;
      end
    end
  end

endmodule

@@ src/spcg_queue.sv @@
// Two-entry queue between the classifier and the capture sequencer.
// Depends on spcg_pkg.
module spcg_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  spcg_pkg::q_item_t push_item,
  output logic              push_ready,
  input  logic              pop,
  output logic              head_valid,
  output spcg_pkg::q_item_t head_item
);
  import spcg_pkg::*;

  q_item_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;

  assign push_ready = count_r != QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head_item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ src/spcg_back.sv @@
// Back end: sleep/listen/capture sequencing per lane and the registered result beat.
// Depends on spcg_pkg.
module spcg_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             head_valid,
  input  spcg_pkg::q_item_t                head_item,
  output logic                             pop,
  input  spcg_pkg::cfg_limits_t            limits,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [spcg_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import spcg_pkg::*;

  logic                         awake_r;
  lane_mode_t [LANES-1:0]       lane_r;
  logic [TIME_W-1:0]            count_r;
  logic [TIME_W-1:0]            wake_r;
  logic [TIME_W-1:0]            edge_r;
  logic [LANES-1:0][FILL_W-1:0] fill_r;

  logic                         awake_nxt;
  lane_mode_t [LANES-1:0]       lane_nxt;
  logic [TIME_W-1:0]            count_nxt;
  logic [TIME_W-1:0]            wake_nxt;
  logic [TIME_W-1:0]            edge_nxt;
  logic [LANES-1:0][FILL_W-1:0] fill_nxt;
  logic [LANES-1:0]             start_nxt;
  logic [LANES-1:0]             take_nxt;
  logic [LANES-1:0]             stop_nxt;

  logic                         out_valid_r;
  logic [OUT_DATA_W-1:0]        out_data_r;

  assign pop        = head_valid && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    logic              cap_now;
    logic [CNT_W-1:0]  n_listen;
    logic [CNT_W-1:0]  n_capture;
    logic              time_up;
    awake_nxt = awake_r;
    lane_nxt  = lane_r;
    wake_nxt  = wake_r;
    edge_nxt  = edge_r;
    fill_nxt  = fill_r;
    start_nxt = '0;
    take_nxt  = '0;
    stop_nxt  = '0;
    n_listen  = '0;
    n_capture = '0;
    time_up   = 1'b0;
    count_nxt = count_r + 1'b1;

    if (!awake_r && (count_nxt - wake_r) > TIME_W'(limits.sleep_samples)) begin
      for (int c = 0; c < CHANNELS; c++) lane_nxt[c] = LANE_LISTEN;
      wake_nxt  = count_nxt;
      awake_nxt = 1'b1;
    end

    if (awake_nxt) begin
      for (int c = 0; c < CHANNELS; c++) begin
        cap_now = 1'b0;
        unique case (lane_nxt[c])
          LANE_LISTEN: begin
            if (head_item.over[c]) begin
              lane_nxt[c]  = LANE_CAPTURE;
              fill_nxt[c]  = '0;
              edge_nxt     = count_nxt;
              start_nxt[c] = 1'b1;
              cap_now      = 1'b1;
            end
          end
          LANE_CAPTURE: begin
            if (head_item.over[c]) begin
              cap_now = 1'b1;
            end else begin
              lane_nxt[c] = LANE_SLEEP;
              stop_nxt[c] = 1'b1;
            end
          end
          default: ;
        endcase
        if (cap_now) begin
          if (fill_nxt[c] < FILL_W'(CHUNK_DEPTH)) begin
            fill_nxt[c] = fill_nxt[c] + 1'b1;
            take_nxt[c] = 1'b1;
          end else begin
            lane_nxt[c] = LANE_SLEEP;
            stop_nxt[c] = 1'b1;
          end
        end
      end

      for (int c = 0; c < CHANNELS; c++) begin
        if (lane_nxt[c] == LANE_LISTEN)  n_listen  = n_listen + 1'b1;
        if (lane_nxt[c] == LANE_CAPTURE) n_capture = n_capture + 1'b1;
      end

      if (n_listen == CNT_W'(CHANNELS)) begin
        time_up = (count_nxt - wake_nxt) > TIME_W'(limits.first_ping_wait);
      end else begin
        time_up = (count_nxt - edge_nxt) > TIME_W'(limits.edge_gap_limit);
      end

      if ((n_listen == '0 && n_capture == '0) || (n_capture == '0 && time_up)) begin
        for (int c = 0; c < CHANNELS; c++) begin
          if (lane_nxt[c] == LANE_CAPTURE) stop_nxt[c] = 1'b1;
          lane_nxt[c] = LANE_SLEEP;
        end
        awake_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awake_r     <= 1'b0;
      lane_r      <= {LANES{LANE_SLEEP}};
      count_r     <= '0;
      wake_r      <= '0;
      edge_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        awake_r     <= awake_nxt;
        lane_r      <= lane_nxt;
        count_r     <= count_nxt;
        wake_r      <= wake_nxt;
        edge_r      <= edge_nxt;
        fill_r      <= fill_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= {3'b000, head_item.raw, count_nxt, stop_nxt, take_nxt,
                     start_nxt, awake_nxt};
    end
  end

endmodule
